// ===== hdl/fpsr_pkg.sv =====
// Package for the flow packet sequence recorder.
// Holds sizes, codes, payload structs and control structs shared by all files.
// No dependencies.
`timescale 1ns / 1ps
package fpsr_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [31:0] WRAP_WINDOW = 32'd42949672;

  localparam logic [1:0] CFG_SKIP   = 2'd0;
  localparam logic [1:0] CFG_EMPTY  = 2'd1;
  localparam logic [1:0] CFG_MINLEN = 2'd2;

  typedef enum logic [1:0] {
    ACT_FIRST  = 2'd0,
    ACT_NEXT   = 2'd1,
    ACT_EXPORT = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_PKT    = 2'd0,
    KIND_REC    = 2'd1,
    KIND_EMPTY  = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  typedef struct packed {
    action_t     action;
    logic        from_source;
    logic [7:0]  ip_protocol;
    logic [31:0] tcp_seq;
    logic [31:0] tcp_ack;
    logic [15:0] payload_length;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] total_length;
    logic [15:0] wire_payload_length;
    logic [63:0] timestamp;
    logic [31:0] flow_packets;
    logic        flow_syn_seen;
  } in_item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic        duplicate;
    logic        recorded;
    logic [6:0]  record_count;
    logic        rec_direction;
    logic [15:0] rec_length;
    logic [7:0]  rec_flags;
    logic [63:0] rec_time;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        direction;
    logic [15:0] length;
    logic [7:0]  flags;
    logic [63:0] time_stamp;
  } rec_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } store_ctl_t;

  typedef struct packed {
    logic        skip_duplicates;
    logic        count_empty;
    logic [15:0] remove_max_pkts;
  } cfg_t;

  typedef struct packed {
    logic no_borrow;
    logic in_window;
  } cmp_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage

// ===== hdl/fpsr_in_if.sv =====
// Input channel of the recorder: valid, ready and one packet or export request.
// Depends on fpsr_pkg.
`timescale 1ns / 1ps
interface fpsr_in_if
  import fpsr_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fpsr_out_if.sv =====
// Output channel of the recorder: valid, ready and one result item.
// Depends on fpsr_pkg.
`timescale 1ns / 1ps
interface fpsr_out_if
  import fpsr_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fpsr_cmp_unit.sv =====
// Shared 32-bit subtract and compare unit: a - b, no-borrow and wrap window test.
// Depends on fpsr_pkg.
`timescale 1ns / 1ps
module fpsr_cmp_unit
  import fpsr_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  output cmp_t        res
);
  logic [32:0] diff;

  assign diff          = {1'b0, a} - {1'b0, b};
  assign res.no_borrow = !diff[32];
  assign res.in_window = !diff[32] && (diff[31:0] <= WRAP_WINDOW);
endmodule

// ===== hdl/fpsr_store.sv =====
// Record store: one write port, one read port with registered read data.
// Depends on fpsr_pkg.
`timescale 1ns / 1ps
module fpsr_store
  import fpsr_pkg::*;
(
  input  logic       clk,
  input  store_ctl_t ctl,
  input  rec_t       wdata,
  output rec_t       rdata
);
  rec_t mem [MAX_RECORDS];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[ctl.raddr];
    end
  end
endmodule

// ===== hdl/fpsr_ctrl.sv =====
// Sequencer of the recorder: duplicate check over the shared compare unit,
// per-direction last values, store writes and result streaming.
// Depends on fpsr_pkg, fpsr_in_if, fpsr_out_if, fpsr_cmp_unit.
`timescale 1ns / 1ps
module fpsr_ctrl
  import fpsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  fpsr_in_if.sink    pkt,
  fpsr_out_if.source res,
  output store_ctl_t ctl,
  output rec_t       wdata,
  input  rec_t       rdata,
  output stat_t      stat
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SEQ  = 8'b0000_0010,
    S_ACK  = 8'b0000_0100,
    S_RES  = 8'b0000_1000,
    S_EXP  = 8'b0001_0000,
    S_RD   = 8'b0010_0000,
    S_REC  = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t           state;
  in_item_t         item;
  out_item_t        res_q;
  logic [31:0]      last_seq   [2];
  logic [31:0]      last_ack   [2];
  logic [15:0]      last_len   [2];
  logic [7:0]       last_flags [2];
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] rd_idx;
  logic             seq_ok;
  logic [31:0]      unit_a;
  logic [31:0]      unit_b;
  cmp_t             unit_res;
  logic             dup_now;
  logic             rec_now;
  logic             full;
  logic             remove_now;

  fpsr_cmp_unit u_cmp (
    .a   (unit_a),
    .b   (unit_b),
    .res (unit_res)
  );

  always_comb begin
    case (state)
      S_SEQ: begin
        unit_a = last_seq[item.from_source];
        unit_b = item.tcp_seq;
      end
      S_ACK: begin
        unit_a = last_ack[item.from_source];
        unit_b = item.tcp_ack;
      end
      default: begin
        unit_a = {16'b0, cfg.remove_max_pkts};
        unit_b = item.flow_packets;
      end
    endcase
  end

  assign full    = !(count < CNT_W'(MAX_RECORDS));
  assign dup_now = cfg.skip_duplicates && (item.ip_protocol == PROTO_TCP) && seq_ok
                   && unit_res.in_window
                   && (item.payload_length == last_len[item.from_source])
                   && (item.tcp_flag_bits == last_flags[item.from_source])
                   && (count != '0);
  assign rec_now = !dup_now && ((item.total_length != 16'd0) || cfg.count_empty) && !full;
  assign remove_now = item.flow_syn_seen && unit_res.no_borrow;

  assign wdata.direction  = item.from_source;
  assign wdata.length     = item.wire_payload_length;
  assign wdata.flags      = item.tcp_flag_bits;
  assign wdata.time_stamp = item.timestamp;

  assign ctl.we    = (state == S_ACK) && rec_now;
  assign ctl.waddr = count[IDX_W-1:0];
  assign ctl.re    = (state == S_EXP) || ((state == S_REC) && res.ready);
  assign ctl.raddr = (state == S_EXP) ? '0 : rd_idx + IDX_W'(1);

  assign pkt.ready  = (state == S_IDLE);
  assign res.valid  = (state == S_RES) || (state == S_REC);
  assign res.data   = res_q;
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      last_seq   <= '{default: '0};
      last_ack   <= '{default: '0};
      last_len   <= '{default: '0};
      last_flags <= '{default: '0};
    end else begin
      case (state)
        S_IDLE: begin
          if (pkt.valid) begin
            item <= pkt.data;
            case (pkt.data.action)
              ACT_FIRST: begin
                count      <= '0;
                last_seq   <= '{default: '0};
                last_ack   <= '{default: '0};
                last_len   <= '{default: '0};
                last_flags <= '{default: '0};
                state      <= S_SEQ;
              end
              ACT_NEXT:   state <= S_SEQ;
              ACT_EXPORT: state <= S_EXP;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_SEQ: begin
          seq_ok <= unit_res.in_window;
          state  <= S_ACK;
        end
        S_ACK: begin
          if (!dup_now) begin
            last_seq[item.from_source]   <= item.tcp_seq;
            last_ack[item.from_source]   <= item.tcp_ack;
            last_len[item.from_source]   <= item.payload_length;
            last_flags[item.from_source] <= item.tcp_flag_bits;
          end
          if (rec_now) begin
            count <= count + CNT_W'(1);
          end
          res_q <= '{result_kind: KIND_PKT, duplicate: dup_now, recorded: rec_now,
                     record_count: 7'(rec_now ? count + CNT_W'(1) : count),
                     rec_direction: 1'b0, rec_length: '0, rec_flags: '0, rec_time: '0,
                     last: 1'b1};
          state <= S_RES;
        end
        S_EXP: begin
          res_q  <= '{result_kind: remove_now ? KIND_REMOVE : KIND_EMPTY,
                      duplicate: 1'b0, recorded: 1'b0, record_count: 7'(count),
                      rec_direction: 1'b0, rec_length: '0, rec_flags: '0, rec_time: '0,
                      last: 1'b1};
          rd_idx <= '0;
          if (remove_now || (count == '0)) begin
            state <= S_RES;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          res_q <= '{result_kind: KIND_REC, duplicate: 1'b0, recorded: 1'b0,
                     record_count: 7'(count), rec_direction: rdata.direction,
                     rec_length: rdata.length, rec_flags: rdata.flags,
                     rec_time: rdata.time_stamp,
                     last: (CNT_W'(rd_idx) + CNT_W'(1)) == count};
          state <= S_REC;
        end
        S_REC: begin
          if (res.ready) begin
            if (res_q.last) begin
              state <= S_IDLE;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
              state  <= S_RD;
            end
          end
        end
        S_RES: begin
          if (res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/flow_packet_sequence_recorder.sv =====
// Top level of the flow packet sequence recorder: configuration registers,
// sequencer and record store. Depends on fpsr_pkg, fpsr_in_if, fpsr_out_if,
// fpsr_ctrl, fpsr_store.
//
//   channel   dir  handshake        payload
//   pkt       in   valid / ready    in_item_t: packet or export request
//   res       out  valid / ready    out_item_t: packet result or export record
//   cfg       in   cfg_we           cfg_index, cfg_data
//
// A packet goes through accept, seq compare, ack compare and update, then result;
// the shared 32-bit compare unit keeps the seq and ack compares apart.
// Export goes through accept and decide, then one result for remove or empty,
// or a store read step and a result step per stored record (registered store read).
// Not ready while a request is in work or its results wait to be taken.
// Synchronous reset clears state, counts and last values and loads the configuration defaults; no clear pass.
`timescale 1ns / 1ps
module flow_packet_sequence_recorder
  import fpsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fpsr_in_if.sink     pkt,
  fpsr_out_if.source  res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  cfg_t       cfg;
  store_ctl_t ctl;
  rec_t       wdata;
  rec_t       rdata;
  stat_t      stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{skip_duplicates: 1'b0, count_empty: 1'b0, remove_max_pkts: 16'd1};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SKIP:   cfg.skip_duplicates <= cfg_data[0];
        CFG_EMPTY:  cfg.count_empty     <= cfg_data[0];
        CFG_MINLEN: cfg.remove_max_pkts <= cfg_data;
        default: ;
      endcase
    end
  end

  fpsr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .pkt   (pkt),
    .res   (res),
    .ctl   (ctl),
    .wdata (wdata),
    .rdata (rdata),
    .stat  (stat)
  );

  fpsr_store u_store (
    .clk   (clk),
    .ctl   (ctl),
    .wdata (wdata),
    .rdata (rdata)
  );

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(pkt.ready && res.valid))
    else $error("input ready while a result waits");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    ctl.we |-> (stat.count < CNT_W'(MAX_RECORDS)))
    else $error("store write with store full");

  a_rec_gap: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && (res.data.result_kind == KIND_REC) && !res.data.last)
    |=> !res.valid)
    else $error("record result without store read");

  a_unused_action: assert property (@(posedge clk) disable iff (rst)
    (pkt.valid && pkt.ready && (pkt.data.action == ACT_NONE)) |=> pkt.ready)
    else $error("unused action code not dropped");
endmodule

// ===== tb/flow_packet_sequence_recorder_tb.sv =====
// Testbench for flow_packet_sequence_recorder: directed and random packet and export requests,
// every result checked in order against a behavioral copy of the record store and config.
// Depends on fpsr_pkg, fpsr_in_if, fpsr_out_if and the recorder RTL.
`timescale 1ns / 1ps
module flow_packet_sequence_recorder_tb;
  import fpsr_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int ITEMS_PER_PHASE = 67;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  fpsr_in_if  pkt_ch ();
  fpsr_out_if res_ch ();

  flow_packet_sequence_recorder uut (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic        skip_dups;
  logic        keep_empty;
  logic [15:0] short_flow_len;
  logic [31:0] seen_seq [2];
  logic [31:0] seen_ack [2];
  logic [15:0] seen_len [2];
  logic [7:0]  seen_flags [2];
  int          kept_count;
  rec_t        kept_records [MAX_RECORDS];

  in_item_t    requests_waiting [$];
  out_item_t   results_due [$];
  int          request_count = 0;
  int          error_count   = 0;
  int          cycle_count   = 0;
  int          send_idle_pct = 19;
  int          recv_idle_pct = 72;
  int          rx_hold_req   = 0;
  int          rx_hold_seen  = 0;
  int          rx_hold_left  = 0;
  logic        req_taken     = 1'b0;
  logic [63:0] stamp_now;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic not_above(input logic [31:0] cur, input logic [31:0] prev);
    return (cur <= prev) && ((prev - cur) <= WRAP_WINDOW);
  endfunction

  task automatic track_request(input in_item_t req);
    out_item_t r;
    logic      dir;
    logic      dup;
    logic      rec;
    r = '0;
    r.last = 1'b1;
    case (req.action)
      ACT_FIRST, ACT_NEXT: begin
        if (req.action == ACT_FIRST) begin
          seen_seq   = '{default: '0};
          seen_ack   = '{default: '0};
          seen_len   = '{default: '0};
          seen_flags = '{default: '0};
          kept_count = 0;
        end
        dir = req.from_source;
        dup = skip_dups && req.ip_protocol == PROTO_TCP
              && not_above(req.tcp_seq, seen_seq[dir])
              && not_above(req.tcp_ack, seen_ack[dir])
              && req.payload_length == seen_len[dir]
              && req.tcp_flag_bits == seen_flags[dir]
              && kept_count != 0;
        rec = 1'b0;
        if (!dup) begin
          seen_seq[dir]   = req.tcp_seq;
          seen_ack[dir]   = req.tcp_ack;
          seen_len[dir]   = req.payload_length;
          seen_flags[dir] = req.tcp_flag_bits;
          if ((req.total_length != 0 || keep_empty) && kept_count < MAX_RECORDS) begin
            kept_records[kept_count] = '{direction: dir, length: req.wire_payload_length,
                                         flags: req.tcp_flag_bits, time_stamp: req.timestamp};
            kept_count++;
            rec = 1'b1;
          end
        end
        r.result_kind  = KIND_PKT;
        r.duplicate    = dup;
        r.recorded     = rec;
        r.record_count = 7'(kept_count);
        results_due = {results_due, r};
      end
      ACT_EXPORT: begin
        r.record_count = 7'(kept_count);
        if (req.flow_syn_seen && req.flow_packets <= 32'(short_flow_len)) begin
          r.result_kind = KIND_REMOVE;
          results_due = {results_due, r};
        end else if (kept_count == 0) begin
          r.result_kind = KIND_EMPTY;
          results_due = {results_due, r};
        end else begin
          for (int i = 0; i < kept_count; i++) begin
            r.result_kind   = KIND_REC;
            r.rec_direction = kept_records[i].direction;
            r.rec_length    = kept_records[i].length;
            r.rec_flags     = kept_records[i].flags;
            r.rec_time      = kept_records[i].time_stamp;
            r.last          = (i == kept_count - 1);
            results_due = {results_due, r};
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic string show_result(input out_item_t r);
    return $sformatf("kind %0d dup %0b rec %0b count %0d dir %0b len %0h flags %0h time %0h last %0b",
                     r.result_kind, r.duplicate, r.recorded, r.record_count, r.rec_direction,
                     r.rec_length, r.rec_flags, r.rec_time, r.last);
  endfunction

  function automatic in_item_t rand_request();
    in_item_t req;
    req.action              = action_t'($urandom_range(3));
    req.from_source         = 1'($urandom_range(1));
    req.ip_protocol         = 8'($urandom);
    req.tcp_seq             = $urandom;
    req.tcp_ack             = $urandom;
    req.payload_length      = 16'($urandom);
    req.tcp_flag_bits       = 8'($urandom);
    req.total_length        = 16'($urandom);
    req.wire_payload_length = 16'($urandom);
    req.timestamp           = {$urandom, $urandom};
    req.flow_packets        = $urandom;
    req.flow_syn_seen       = 1'($urandom_range(1));
    return req;
  endfunction

  function automatic in_item_t tcp_request(input action_t act, input logic dir,
                                           input logic [31:0] seq, input logic [31:0] ack,
                                           input logic [15:0] plen, input logic [7:0] flags,
                                           input logic [15:0] total);
    in_item_t req;
    req = rand_request();
    req.action              = act;
    req.from_source         = dir;
    req.ip_protocol         = PROTO_TCP;
    req.tcp_seq             = seq;
    req.tcp_ack             = ack;
    req.payload_length      = plen;
    req.tcp_flag_bits       = flags;
    req.total_length        = total;
    req.wire_payload_length = plen;
    return req;
  endfunction

  function automatic in_item_t export_request(input logic [31:0] pkts, input logic syn);
    in_item_t req;
    req = rand_request();
    req.action        = ACT_EXPORT;
    req.flow_packets  = pkts;
    req.flow_syn_seen = syn;
    return req;
  endfunction

  function automatic void push_request(input in_item_t req);
    requests_waiting = {requests_waiting, req};
    if (req.action != ACT_NONE) request_count++;
  endfunction

  task automatic queue_flow(input int n);
    in_item_t    req;
    in_item_t    sent [2];
    bit          have [2];
    logic [31:0] next_seq [2];
    logic        tcp;
    logic        dir;
    logic [15:0] plen;
    tcp = ($urandom_range(9) != 0);
    have = '{default: 1'b0};
    next_seq[0] = $urandom;
    next_seq[1] = $urandom;
    for (int k = 0; k < n; k++) begin
      dir = 1'($urandom_range(1));
      stamp_now += 64'($urandom_range(1, 5000));
      if (have[dir] && $urandom_range(3) == 0) begin
        // retransmit, exact or altered in seq, ack or flags
        req = sent[dir];
        case ($urandom_range(4))
          0: ;
          1: req.tcp_seq -= 32'($urandom_range(1, 3000));
          2: req.tcp_seq -= WRAP_WINDOW + 32'($urandom_range(1));
          3: req.tcp_ack -= 32'($urandom_range(1, 3));
          default: req.tcp_flag_bits ^= 8'h01;
        endcase
      end else begin
        plen = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1460));
        req = tcp_request(ACT_NEXT, dir, next_seq[dir], next_seq[!dir], plen,
                          ($urandom_range(3) == 0) ? 8'($urandom) : 8'h18,
                          ($urandom_range(9) == 0) ? 16'd0 : plen + 16'd40);
        if (!tcp) req.ip_protocol = 8'($urandom);
        next_seq[dir] += 32'(plen);
        sent[dir] = req;
        have[dir] = 1'b1;
      end
      req.action = (k == 0 && $urandom_range(7) != 0) ? ACT_FIRST : ACT_NEXT;
      req.timestamp = stamp_now;
      push_request(req);
    end
    if ($urandom_range(7) != 0)
      push_request(export_request(($urandom_range(3) == 0) ? $urandom : n,
                                  1'($urandom_range(1))));
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_SKIP:   skip_dups = value[0];
      CFG_EMPTY:  keep_empty = value[0];
      CFG_MINLEN: short_flow_len = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (requests_waiting.size() != 0 || pkt_ch.valid || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!pkt_ch.valid || req_taken) begin
      if (requests_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        pkt_ch.data  <= requests_waiting.pop_front();
        pkt_ch.valid <= 1'b1;
      end else begin
        pkt_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= RX_HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= pkt_ch.valid && pkt_ch.ready;
      if (pkt_ch.valid && pkt_ch.ready) track_request(pkt_ch.data);
      if (res_ch.valid && res_ch.ready) begin
        if (results_due.size() == 0) begin
          if (error_count < 10)
            $display("cycle %0d: result with none due: %s", cycle_count,
                     show_result(res_ch.data));
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (res_ch.data.result_kind !== want.result_kind
              || res_ch.data.duplicate !== want.duplicate
              || res_ch.data.recorded !== want.recorded
              || res_ch.data.record_count !== want.record_count
              || res_ch.data.rec_direction !== want.rec_direction
              || res_ch.data.rec_length !== want.rec_length
              || res_ch.data.rec_flags !== want.rec_flags
              || res_ch.data.rec_time !== want.rec_time
              || res_ch.data.last !== want.last) begin
            if (error_count < 10)
              $display("cycle %0d: result mismatch\n  expected %s\n  actual   %s", cycle_count,
                       show_result(want), show_result(res_ch.data));
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : run
    in_item_t    req;
    int          phase;
    int          phase_end;
    int          pick;
    logic        skip_v;
    logic        empty_v;
    logic [15:0] min_v;
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SKIP;
    cfg_data       = '0;
    pkt_ch.valid   = 1'b0;
    pkt_ch.data    = '0;
    res_ch.ready   = 1'b0;
    seen_seq       = '{default: '0};
    seen_ack       = '{default: '0};
    seen_len       = '{default: '0};
    seen_flags     = '{default: '0};
    kept_count     = 0;
    skip_dups      = 1'b0;
    keep_empty     = 1'b0;
    short_flow_len = 16'd1;
    stamp_now      = {$urandom, $urandom};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(CFG_SKIP, 16'd1);
    write_reg(CFG_EMPTY, 16'd0);
    write_reg(CFG_MINLEN, 16'd1);

    push_request(export_request(32'd5, 1'b0));
    push_request(export_request(32'd1, 1'b1));
    push_request(tcp_request(ACT_FIRST, 1'b1, 32'h8000_0000, 32'h8000_0000, 16'd100, 8'h18,
                             16'd140));
    push_request(tcp_request(ACT_NEXT, 1'b1, 32'h8000_0000, 32'h8000_0000, 16'd100, 8'h18,
                             16'd140));
    push_request(tcp_request(ACT_NEXT, 1'b1, 32'h8000_0000 - WRAP_WINDOW, 32'h8000_0000,
                             16'd100, 8'h18, 16'd140));
    push_request(tcp_request(ACT_NEXT, 1'b1, 32'h8000_0000 - WRAP_WINDOW - 32'd1,
                             32'h8000_0000, 16'd100, 8'h18, 16'd140));
    push_request(tcp_request(ACT_NEXT, 1'b0, '0, '0, '0, '0, 16'd40));
    req = tcp_request(ACT_NEXT, 1'b0, '0, '0, '0, '0, 16'd40);
    req.ip_protocol = 8'd17;
    push_request(req);
    req = tcp_request(ACT_NEXT, 1'b1, 32'd7, 32'd7, 16'd0, 8'h10, 16'd0);
    push_request(req);
    req = '1;
    req.action = ACT_NEXT;
    push_request(req);
    req = '1;
    push_request(req);
    push_request(export_request(32'd2, 1'b1));
    push_request(export_request(32'd0, 1'b0));
    req = '0;
    req.action = ACT_FIRST;
    push_request(req);
    push_request(export_request('1, 1'b1));
    push_request(tcp_request(ACT_FIRST, 1'b0, 32'd100, 32'd100, 16'd10, 8'h10, 16'd50));
    push_request(tcp_request(ACT_NEXT, 1'b0, 32'd100, '1, 16'd10, 8'h10, 16'd50));
    push_request(tcp_request(ACT_NEXT, 1'b0, 32'd100, '1, 16'd10, 8'h10, 16'd50));
    push_request(export_request(32'd3, 1'b1));
    wait_drained();

    for (phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin send_idle_pct = 19; recv_idle_pct = 72; end
        1: begin send_idle_pct = 72; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      skip_v  = (phase != 1 && phase != 3);
      empty_v = (phase == 1 || phase == 2 || phase == 5);
      case (phase)
        0: min_v = 16'd1;
        1: min_v = 16'd0;
        2: min_v = 16'hFFFF;
        3: min_v = 16'($urandom);
        4: min_v = 16'd3;
        default: min_v = 16'($urandom_range(40));
      endcase
      write_reg(CFG_SKIP, {15'd0, skip_v});
      write_reg(CFG_EMPTY, {15'd0, empty_v});
      write_reg(CFG_MINLEN, min_v);

      phase_end = request_count + ITEMS_PER_PHASE;
      if (phase == 0) queue_flow(36);
      // stall the result side long enough to back up the input
      if (phase == 1) rx_hold_req++;
      while (request_count < phase_end) begin
        pick = $urandom_range(19);
        if (pick < 15)
          queue_flow(($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10));
        else if (pick < 18)
          push_request(rand_request());
        else
          push_request(export_request(($urandom_range(1) == 0) ? $urandom
                                      : 32'(short_flow_len) + $urandom_range(1),
                                      1'($urandom_range(1))));
      end
      wait_drained();
    end

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
